/* src/fum_pkg.sv */
// ----------------------------------------------------------------------------
// fum_pkg
// Shared constants, item sideband type and arithmetic helpers of the
// fisheye undistortion map generator.
// ----------------------------------------------------------------------------
package fum_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int MAX_POLY_TERMS = 16;
   localparam int IDX_W          = $clog2(MAX_POLY_TERMS);
   localparam int SQRT_STEPS     = FRAC_BITS + 14;
   localparam int CORDIC_STEPS   = FRAC_BITS + 2;
   localparam int QUO_BITS       = FRAC_BITS + 2;
   localparam int OFS_W          = 14;
   localparam int SUM_W          = 28;
   localparam int ROOT_W         = 31;
   localparam int REM_W          = 34;
   localparam int DREM_W         = 32;
   localparam int CORD_W         = 33;
   localparam int ANG_W          = 20;
   localparam int UNIT_W         = QUO_BITS + 1;
   localparam int DEPTH_W        = 10;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_MAP  = 1'b1;

   localparam logic [3:0] CSR_ROWS  = 4'd0;
   localparam logic [3:0] CSR_COLS  = 4'd1;
   localparam logic [3:0] CSR_AFF_C = 4'd2;
   localparam logic [3:0] CSR_AFF_D = 4'd3;
   localparam logic [3:0] CSR_AFF_E = 4'd4;
   localparam logic [3:0] CSR_CROW  = 4'd5;
   localparam logic [3:0] CSR_CCOL  = 4'd6;
   localparam logic [3:0] CSR_TERMS = 4'd7;

   localparam logic [31:0] ATAN_Q30 [30] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2
   };

   typedef struct packed {
      logic                    valid;
      logic                    mode;
      logic [IDX_W-1:0]        coeff_index;
      logic signed [31:0]      coeff_value;
      logic signed [OFS_W-1:0] ofs_a;
      logic signed [OFS_W-1:0] ofs_b;
      logic                    zero;
   } side_type;

   function automatic logic signed [ANG_W-1:0] atan_step(input int i);
      logic [31:0] v;
      v = ATAN_Q30[i] + (32'd1 << (29 - FRAC_BITS));
      return ANG_W'(v >> (30 - FRAC_BITS));
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

/* src/fum_sqrt.sv */
// ----------------------------------------------------------------------------
// fum_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// ----------------------------------------------------------------------------
module fum_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  fum_pkg::side_type         side_i,
   input  logic [fum_pkg::SUM_W-1:0] sum_i,
   output fum_pkg::side_type         side_o,
   output logic [fum_pkg::ROOT_W-1:0] root_o
);
   import fum_pkg::*;

   side_type           side_ff [SQRT_STEPS];
   logic [SUM_W-1:0]   sum_ff  [SQRT_STEPS];
   logic [REM_W-1:0]   rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0]  root_ff [SQRT_STEPS];
   side_type           side_in [SQRT_STEPS];
   logic [SUM_W-1:0]   sum_in  [SQRT_STEPS];
   logic [REM_W-1:0]   rem_in  [SQRT_STEPS];
   logic [ROOT_W-1:0]  root_in [SQRT_STEPS];

   always_comb begin
      side_type          ps;
      logic [SUM_W-1:0]  psum;
      logic [REM_W-1:0]  prem;
      logic [ROOT_W-1:0] proot;
      logic [1:0]        pair;
      logic [REM_W-1:0]  remw;
      logic [REM_W-1:0]  trial;
      int                p;
      for (int j = 0; j < SQRT_STEPS; j++) begin
         if (j == 0) begin
            ps    = side_i;
            psum  = sum_i;
            prem  = '0;
            proot = '0;
         end else begin
            ps    = side_ff[j-1];
            psum  = sum_ff[j-1];
            prem  = rem_ff[j-1];
            proot = root_ff[j-1];
         end
         p = SQRT_STEPS - 1 - j;
         pair = (p >= FRAC_BITS) ? 2'(psum >> (2 * (p - FRAC_BITS))) : 2'b00;
         remw  = {prem[REM_W-3:0], pair};
         trial = REM_W'({proot, 2'b01});
         side_in[j] = ps;
         sum_in[j]  = psum;
         if (remw >= trial) begin
            rem_in[j]  = remw - trial;
            root_in[j] = {proot[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[j]  = remw;
            root_in[j] = {proot[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SQRT_STEPS; j++) begin
            side_ff[j].valid <= 1'b0;
         end
      end else if (en) begin
         for (int j = 0; j < SQRT_STEPS; j++) begin
            side_ff[j] <= side_in[j];
            sum_ff[j]  <= sum_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign side_o = side_ff[SQRT_STEPS-1];
   assign root_o = root_ff[SQRT_STEPS-1];

endmodule

/* src/fum_horner.sv */
// ----------------------------------------------------------------------------
// fum_horner
// Pipelined Horner evaluation of rho(theta), one coefficient per stage.
// Each stage keeps its own coefficient, loaded as a load item passes.
// ----------------------------------------------------------------------------
module fum_horner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic [fum_pkg::IDX_W-1:0]         terms_m1,
   input  fum_pkg::side_type                 side_i,
   input  logic signed [fum_pkg::ANG_W-1:0]  theta_i,
   input  logic signed [fum_pkg::UNIT_W-1:0] ua_i,
   input  logic signed [fum_pkg::UNIT_W-1:0] ub_i,
   output fum_pkg::side_type                 side_o,
   output logic signed [31:0]                rho_o,
   output logic signed [fum_pkg::UNIT_W-1:0] ua_o,
   output logic signed [fum_pkg::UNIT_W-1:0] ub_o
);
   import fum_pkg::*;

   logic signed [31:0]       coef_ff  [MAX_POLY_TERMS];
   side_type                 side_ff  [MAX_POLY_TERMS];
   logic signed [ANG_W-1:0]  theta_ff [MAX_POLY_TERMS];
   logic signed [UNIT_W-1:0] ua_ff    [MAX_POLY_TERMS];
   logic signed [UNIT_W-1:0] ub_ff    [MAX_POLY_TERMS];
   logic signed [31:0]       rho_ff   [MAX_POLY_TERMS];
   side_type                 side_in  [MAX_POLY_TERMS];
   logic signed [ANG_W-1:0]  theta_in [MAX_POLY_TERMS];
   logic signed [UNIT_W-1:0] ua_in    [MAX_POLY_TERMS];
   logic signed [UNIT_W-1:0] ub_in    [MAX_POLY_TERMS];
   logic signed [31:0]       rho_in   [MAX_POLY_TERMS];

   always_comb begin
      logic signed [31:0] prho;
      logic signed [63:0] prod;
      logic signed [63:0] acc;
      logic [IDX_W-1:0]   k;
      for (int j = 0; j < MAX_POLY_TERMS; j++) begin
         k = IDX_W'(MAX_POLY_TERMS - 1 - j);
         if (j == 0) begin
            side_in[j]  = side_i;
            theta_in[j] = theta_i;
            ua_in[j]    = ua_i;
            ub_in[j]    = ub_i;
            prho        = '0;
         end else begin
            side_in[j]  = side_ff[j-1];
            theta_in[j] = theta_ff[j-1];
            ua_in[j]    = ua_ff[j-1];
            ub_in[j]    = ub_ff[j-1];
            prho        = rho_ff[j-1];
         end
         prod = prho * theta_in[j];
         acc  = (prod >>> FRAC_BITS) + coef_ff[k];
         if (k == terms_m1) begin
            rho_in[j] = coef_ff[k];
         end else if (k < terms_m1) begin
            rho_in[j] = sat32(acc);
         end else begin
            rho_in[j] = prho;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_POLY_TERMS; j++) begin
            side_ff[j].valid <= 1'b0;
         end
      end else if (en) begin
         for (int j = 0; j < MAX_POLY_TERMS; j++) begin
            side_ff[j]  <= side_in[j];
            theta_ff[j] <= theta_in[j];
            ua_ff[j]    <= ua_in[j];
            ub_ff[j]    <= ub_in[j];
            rho_ff[j]   <= rho_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < MAX_POLY_TERMS; j++) begin
            if (side_in[j].valid && side_in[j].mode == MODE_LOAD &&
                side_in[j].coeff_index == IDX_W'(MAX_POLY_TERMS - 1 - j)) begin
               coef_ff[MAX_POLY_TERMS-1-j] <= side_in[j].coeff_value;
            end
         end
      end
   end

   assign side_o = side_ff[MAX_POLY_TERMS-1];
   assign rho_o  = rho_ff[MAX_POLY_TERMS-1];
   assign ua_o   = ua_ff[MAX_POLY_TERMS-1];
   assign ub_o   = ub_ff[MAX_POLY_TERMS-1];

endmodule

/* src/fisheye_undistort_map_generator.sv */
// ----------------------------------------------------------------------------
// fisheye_undistort_map_generator
// Source-image coordinate generator for fisheye undistortion.
//
// Items enter on req_ (tuser = mode). A load item writes one polynomial
// coefficient and gives no result; a map item gives one rsp_ item with the
// source coordinates of pixel (pixel_row, pixel_col), Q16.16, saturated.
// Registers are written on csr_ (always ready); the user must write them only
// while no item is in flight, which the block itself does not enforce.
// Throughput is one item per cycle while rsp_ does not stall. From acceptance
// to rsp_tvalid an item passes 3 offset/square stages, 30 square-root stages,
// 18 CORDIC stages with the two direction dividers beside them, 16 Horner
// stages and 3 scaling and affine stages, the last being the output register.
// A load item takes effect for every map item accepted after it.
// When rsp_tready is low with a result pending, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated.
// Reset clears the pipeline valid bits and loads the register defaults;
// the coefficient table holds no defined value until it is loaded.
// ----------------------------------------------------------------------------
module fisheye_undistort_map_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // coeff_index[3:0], coeff_value[35:4],
                                    // pixel_row[47:36], pixel_col[59:48]
   input  logic [0:0]  req_tuser,   // mode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // source_x[31:0], source_y[63:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);
   import fum_pkg::*;

   logic [12:0]        rows_ff, cols_ff;
   logic signed [31:0] aff_c_ff, aff_d_ff, aff_e_ff;
   logic [27:0]        crow_ff, ccol_ff;
   logic [4:0]         terms_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [25:0]        depth_prod;
   logic [IDX_W-1:0]   terms_m1;
   logic               adv;

   assign csr_ready = 1'b1;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= 13'd480;
         cols_ff  <= 13'd640;
         aff_c_ff <= 32'sd65536;
         aff_d_ff <= 32'sd0;
         aff_e_ff <= 32'sd0;
         crow_ff  <= 28'd15728640;
         ccol_ff  <= 28'd20971520;
         terms_ff <= 5'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROWS:  rows_ff  <= csr_data[12:0];
            CSR_COLS:  cols_ff  <= csr_data[12:0];
            CSR_AFF_C: aff_c_ff <= csr_data;
            CSR_AFF_D: aff_d_ff <= csr_data;
            CSR_AFF_E: aff_e_ff <= csr_data;
            CSR_CROW:  crow_ff  <= csr_data[27:0];
            CSR_CCOL:  ccol_ff  <= csr_data[27:0];
            CSR_TERMS: terms_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // divide by ten through the reciprocal
   assign depth_prod = {13'd0, cols_ff} * 26'd6554;

   always_ff @(posedge clock) begin
      depth_ff <= depth_prod[16 +: DEPTH_W];
   end

   always_comb begin
      if (terms_ff == 5'd0) begin
         terms_m1 = '0;
      end else if (terms_ff > 5'(MAX_POLY_TERMS)) begin
         terms_m1 = IDX_W'(MAX_POLY_TERMS - 1);
      end else begin
         terms_m1 = IDX_W'(terms_ff - 5'd1);
      end
   end

   // offsets, squares, sum
   side_type          s1_ff, s1_in, s2_ff, s3_ff, s3_in;
   logic [SUM_W-1:0]  sqa_ff, sqb_ff, sum_ff;

   always_comb begin
      s1_in.valid       = req_tvalid;
      s1_in.mode        = req_tuser[0];
      s1_in.coeff_index = req_tdata[3:0];
      s1_in.coeff_value = req_tdata[35:4];
      s1_in.ofs_a       = $signed({1'b0, req_tdata[47:36], 1'b0}) - $signed({1'b0, rows_ff});
      s1_in.ofs_b       = $signed({1'b0, req_tdata[59:48], 1'b0}) - $signed({1'b0, cols_ff});
      s1_in.zero        = 1'b0;
      s3_in             = s2_ff;
      s3_in.zero        = (sqa_ff + sqb_ff) == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s1_ff;
         sqa_ff <= SUM_W'(s1_ff.ofs_a * s1_ff.ofs_a);
         sqb_ff <= SUM_W'(s1_ff.ofs_b * s1_ff.ofs_b);
         s3_ff  <= s3_in;
         sum_ff <= sqa_ff + sqb_ff;
      end
   end

   side_type          sq_side;
   logic [ROOT_W-1:0] sq_root;

   fum_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .side_i (s3_ff),
      .sum_i  (sum_ff),
      .side_o (sq_side),
      .root_o (sq_root)
   );

   // CORDIC vectoring beside the two restoring dividers
   side_type                cs_ff [CORDIC_STEPS];
   logic signed [CORD_W-1:0] cx_ff [CORDIC_STEPS];
   logic signed [CORD_W-1:0] cy_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0]  cz_ff [CORDIC_STEPS];
   logic [ROOT_W-1:0]        cr_ff [CORDIC_STEPS];
   logic [DREM_W-1:0]        ra_ff [CORDIC_STEPS];
   logic [DREM_W-1:0]        rb_ff [CORDIC_STEPS];
   logic [QUO_BITS-1:0]      qa_ff [CORDIC_STEPS];
   logic [QUO_BITS-1:0]      qb_ff [CORDIC_STEPS];
   side_type                cs_in [CORDIC_STEPS];
   logic signed [CORD_W-1:0] cx_in [CORDIC_STEPS];
   logic signed [CORD_W-1:0] cy_in [CORDIC_STEPS];
   logic signed [ANG_W-1:0]  cz_in [CORDIC_STEPS];
   logic [ROOT_W-1:0]        cr_in [CORDIC_STEPS];
   logic [DREM_W-1:0]        ra_in [CORDIC_STEPS];
   logic [DREM_W-1:0]        rb_in [CORDIC_STEPS];
   logic [QUO_BITS-1:0]      qa_in [CORDIC_STEPS];
   logic [QUO_BITS-1:0]      qb_in [CORDIC_STEPS];

   logic [OFS_W-2:0] mag_a, mag_b;
   logic signed [CORD_W-1:0] y_init;

   assign mag_a  = (OFS_W-1)'(sq_side.ofs_a[OFS_W-1] ? -sq_side.ofs_a : sq_side.ofs_a);
   assign mag_b  = (OFS_W-1)'(sq_side.ofs_b[OFS_W-1] ? -sq_side.ofs_b : sq_side.ofs_b);
   assign y_init = -$signed({{(CORD_W-DEPTH_W-FRAC_BITS-1){1'b0}}, depth_ff,
                             {(FRAC_BITS+1){1'b0}}});

   always_comb begin
      side_type                ps;
      logic signed [CORD_W-1:0] px, py;
      logic signed [ANG_W-1:0]  pz;
      logic [ROOT_W-1:0]        pr;
      logic [DREM_W-1:0]        pra, prb;
      logic [QUO_BITS-1:0]      pqa, pqb;
      logic [DREM_W:0]          wa, wb, rt;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (i == 0) begin
            ps  = sq_side;
            px  = $signed({{(CORD_W-ROOT_W){1'b0}}, sq_root});
            py  = y_init;
            pz  = '0;
            pr  = sq_root;
            pra = DREM_W'({mag_a, {(2*FRAC_BITS-QUO_BITS){1'b0}}});
            prb = DREM_W'({mag_b, {(2*FRAC_BITS-QUO_BITS){1'b0}}});
            pqa = '0;
            pqb = '0;
         end else begin
            ps  = cs_ff[i-1];
            px  = cx_ff[i-1];
            py  = cy_ff[i-1];
            pz  = cz_ff[i-1];
            pr  = cr_ff[i-1];
            pra = ra_ff[i-1];
            prb = rb_ff[i-1];
            pqa = qa_ff[i-1];
            pqb = qb_ff[i-1];
         end
         cs_in[i] = ps;
         cr_in[i] = pr;
         if (py < 0) begin
            cx_in[i] = px - (py >>> i);
            cy_in[i] = py + (px >>> i);
            cz_in[i] = pz - atan_step(i);
         end else begin
            cx_in[i] = px + (py >>> i);
            cy_in[i] = py - (px >>> i);
            cz_in[i] = pz + atan_step(i);
         end
         wa = {pra, 1'b0};
         wb = {prb, 1'b0};
         rt = (DREM_W+1)'(pr);
         if (wa >= rt) begin
            ra_in[i] = DREM_W'(wa - rt);
            qa_in[i] = {pqa[QUO_BITS-2:0], 1'b1};
         end else begin
            ra_in[i] = DREM_W'(wa);
            qa_in[i] = {pqa[QUO_BITS-2:0], 1'b0};
         end
         if (wb >= rt) begin
            rb_in[i] = DREM_W'(wb - rt);
            qb_in[i] = {pqb[QUO_BITS-2:0], 1'b1};
         end else begin
            rb_in[i] = DREM_W'(wb);
            qb_in[i] = {pqb[QUO_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cs_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cs_ff[i] <= cs_in[i];
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
            cz_ff[i] <= cz_in[i];
            cr_ff[i] <= cr_in[i];
            ra_ff[i] <= ra_in[i];
            rb_ff[i] <= rb_in[i];
            qa_ff[i] <= qa_in[i];
            qb_ff[i] <= qb_in[i];
         end
      end
   end

   side_type                 ce_side, hz_side;
   logic signed [UNIT_W-1:0] ua, ub, hz_ua, hz_ub;
   logic signed [31:0]       hz_rho;

   assign ce_side = cs_ff[CORDIC_STEPS-1];
   assign ua = ce_side.ofs_a[OFS_W-1] ? -$signed({1'b0, qa_ff[CORDIC_STEPS-1]})
                                      : $signed({1'b0, qa_ff[CORDIC_STEPS-1]});
   assign ub = ce_side.ofs_b[OFS_W-1] ? -$signed({1'b0, qb_ff[CORDIC_STEPS-1]})
                                      : $signed({1'b0, qb_ff[CORDIC_STEPS-1]});

   fum_horner u_horner (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .terms_m1 (terms_m1),
      .side_i   (ce_side),
      .theta_i  (cz_ff[CORDIC_STEPS-1]),
      .ua_i     (ua),
      .ub_i     (ub),
      .side_o   (hz_side),
      .rho_o    (hz_rho),
      .ua_o     (hz_ua),
      .ub_o     (hz_ub)
   );

   // scale, affine products, sum and saturate
   side_type           bx_ff, bm_ff;
   logic signed [31:0] bx_x_ff, bx_y_ff, bm_y_ff;
   logic signed [63:0] xa_prod, ya_prod;
   logic signed [63:0] xc_ff, yd_ff, xe_ff;
   logic signed [63:0] sum_y, sum_x;
   logic signed [31:0] src_x, src_y;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_data_ff;

   always_comb begin
      xa_prod = hz_ua * hz_rho;
      ya_prod = hz_ub * hz_rho;
      sum_y   = (xc_ff >>> FRAC_BITS) + (yd_ff >>> FRAC_BITS) + $signed({1'b0, crow_ff});
      sum_x   = (xe_ff >>> FRAC_BITS) + bm_y_ff + $signed({1'b0, ccol_ff});
      if (bm_ff.zero) begin
         src_x = $signed({4'd0, ccol_ff});
         src_y = $signed({4'd0, crow_ff});
      end else begin
         src_x = sat32(sum_x);
         src_y = sat32(sum_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bx_ff.valid  <= 1'b0;
         bm_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         bx_ff        <= hz_side;
         bx_x_ff      <= sat32(xa_prod >>> FRAC_BITS);
         bx_y_ff      <= sat32(ya_prod >>> FRAC_BITS);
         bm_ff        <= bx_ff;
         bm_y_ff      <= bx_y_ff;
         xc_ff        <= bx_x_ff * aff_c_ff;
         yd_ff        <= bx_y_ff * aff_d_ff;
         xe_ff        <= bx_x_ff * aff_e_ff;
         rsp_valid_ff <= bm_ff.valid && bm_ff.mode == MODE_MAP;
         rsp_data_ff  <= {src_y, src_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* src/fum_checker.sv */
// ----------------------------------------------------------------------------
// fum_props
// Port-level checks of the map generator handshakes.
// ----------------------------------------------------------------------------
module fum_props (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with no pending result");

   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind fisheye_undistort_map_generator fum_props u_fum_props (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
